[sv/tshq_pkg.sv]
package tshq_pkg;

  // Field widths
  localparam int unsigned AngleW   = 16;
  localparam int unsigned SpreadW  = 15;
  localparam int unsigned ScaleW   = 12;
  localparam int unsigned FloorW   = 15;
  localparam int unsigned ScoreW   = 17;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned LimitW   = 20;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // Datapath widths: product of scale and spread, its Q4.8 shifted tolerance,
  // absolute angle difference, saturating sums and counts
  localparam int unsigned ProdW = ScaleW + SpreadW;
  localparam int unsigned TolW  = ProdW - 8;
  localparam int unsigned DiffW = AngleW;
  localparam int unsigned SumW  = 25;
  localparam int unsigned CntW  = 6;

  localparam logic [SumW-1:0] SumMax = '1;
  localparam logic [CntW-1:0] CntMax = '1;

  // Features per vector and the least number of present measurements (70 percent, rounded down)
  localparam int unsigned         FeatureCount = 21;
  localparam logic [CntW-1:0]     SparseMin    = CntW'((FeatureCount * 7) / 10);

  // Score arithmetic: quotient of error_sum * 2^16 / tolerance_sum, one bit per step
  localparam int unsigned         FracW    = 16;
  localparam int unsigned         DivSteps = FracW;
  localparam int unsigned         StepW    = $clog2(DivSteps + 1);
  localparam logic [ScoreW-1:0]   ScoreOne = ScoreW'(1) << FracW;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Register reset values
  localparam logic [ScaleW-1:0] TolScaleRst  = ScaleW'(256);
  localparam logic [FloorW-1:0] TolFloorRst  = FloorW'(48);
  localparam logic [ScoreW-1:0] ThresholdRst = ScoreW'(57672);
  localparam logic [HoldW-1:0]  HoldRst      = HoldW'(300);
  localparam logic [LimitW-1:0] LimitRst     = LimitW'(15000);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgTolScale  = 3'd0,
    CfgTolFloor  = 3'd1,
    CfgThreshold = 3'd2,
    CfgHold      = 3'd3,
    CfgTimeLimit = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ScaleW-1:0] tol_scale;
    logic [FloorW-1:0] tol_floor;
    logic [ScoreW-1:0] score_threshold;
    logic [HoldW-1:0]  hold_ms;
    logic [LimitW-1:0] time_limit_ms;
  } cfg_t;

  // One closed vector, handed from front to back
  typedef struct packed {
    logic [SumW-1:0]  error_sum;
    logic [SumW-1:0]  tolerance_sum;
    logic             no_score;
    logic             sparse;
    logic             new_attempt;
    logic [TimeW-1:0] time_ms;
  } vec_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackDiv,
    BackQual
  } back_state_e;

endpackage

[sv/tshq_front.sv]
module tshq_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tshq_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [tshq_pkg::AngleW-1:0] measured_i,
  input  logic signed [tshq_pkg::AngleW-1:0] template_mean_i,
  input  logic [tshq_pkg::SpreadW-1:0]      template_spread_i,
  input  logic                              measured_present_i,
  input  logic                              template_present_i,
  input  logic                              last_feature_i,
  input  logic                              new_attempt_i,
  input  logic [tshq_pkg::TimeW-1:0]        time_ms_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output tshq_pkg::vec_t                    q_rec_o
);

  localparam int unsigned SumW = tshq_pkg::SumW;
  localparam int unsigned TolW = tshq_pkg::TolW;
  localparam int unsigned CntW = tshq_pkg::CntW;

  logic                             accept;
  logic                             fire;
  logic [tshq_pkg::ProdW-1:0]       prod;
  logic signed [tshq_pkg::AngleW:0] diff;
  logic [tshq_pkg::AngleW:0]        diff_abs;

  logic                           a_valid_q, a_valid_d;
  logic [TolW-1:0]                a_tol_raw_q;
  logic [tshq_pkg::DiffW-1:0]     a_abs_q;
  logic                           a_mp_q, a_tp_q, a_last_q, a_new_q;
  logic [tshq_pkg::TimeW-1:0]     a_time_q;

  logic [SumW-1:0] err_sum_q, err_sum_d;
  logic [SumW-1:0] tol_sum_q, tol_sum_d;
  logic [CntW-1:0] used_cnt_q, used_cnt_d;
  logic [CntW-1:0] pres_cnt_q, pres_cnt_d;

  logic [TolW-1:0] tol;
  logic [TolW-1:0] err;
  logic [SumW:0]   err_add;
  logic [SumW:0]   tol_add;
  logic [SumW-1:0] err_next;
  logic [SumW-1:0] tol_next;
  logic [CntW-1:0] used_next;
  logic [CntW-1:0] pres_next;

  // Hold the input while a closing feature waits for queue space
  assign in_stall_o = a_valid_q & a_last_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign fire       = a_valid_q & ~(a_last_q & q_full_i);

  // Scale the spread and take the absolute difference ahead of the register
  assign prod     = tshq_pkg::ProdW'(cfg_i.tol_scale) * tshq_pkg::ProdW'(template_spread_i);
  assign diff     = (tshq_pkg::AngleW+1)'(measured_i) - (tshq_pkg::AngleW+1)'(template_mean_i);
  assign diff_abs = diff[tshq_pkg::AngleW] ? (tshq_pkg::AngleW+1)'(-diff)
                                           : (tshq_pkg::AngleW+1)'(diff);

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (fire) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_tol_raw_q <= prod[tshq_pkg::ProdW-1:8];
      a_abs_q     <= diff_abs[tshq_pkg::DiffW-1:0];
      a_mp_q      <= measured_present_i;
      a_tp_q      <= template_present_i;
      a_last_q    <= last_feature_i;
      a_new_q     <= new_attempt_i;
      a_time_q    <= time_ms_i;
    end
  end

  // Clamp tolerance and error, then add with saturation
  always_comb begin
    tol = (a_tol_raw_q < TolW'(cfg_i.tol_floor)) ? TolW'(cfg_i.tol_floor) : a_tol_raw_q;
    err = (TolW'(a_abs_q) > tol) ? tol : TolW'(a_abs_q);
    err_add = (SumW+1)'(err_sum_q) + (SumW+1)'(err);
    tol_add = (SumW+1)'(tol_sum_q) + (SumW+1)'(tol);
    err_next  = err_sum_q;
    tol_next  = tol_sum_q;
    used_next = used_cnt_q;
    pres_next = pres_cnt_q;
    if (a_mp_q && pres_cnt_q != tshq_pkg::CntMax) begin
      pres_next = pres_cnt_q + CntW'(1);
    end
    if (a_mp_q && a_tp_q) begin
      err_next = err_add[SumW] ? tshq_pkg::SumMax : err_add[SumW-1:0];
      tol_next = tol_add[SumW] ? tshq_pkg::SumMax : tol_add[SumW-1:0];
      if (used_cnt_q != tshq_pkg::CntMax) begin
        used_next = used_cnt_q + CntW'(1);
      end
    end
  end

  // Advance the accumulators; clear them when a vector closes
  always_comb begin
    err_sum_d  = err_sum_q;
    tol_sum_d  = tol_sum_q;
    used_cnt_d = used_cnt_q;
    pres_cnt_d = pres_cnt_q;
    if (fire) begin
      if (a_last_q) begin
        err_sum_d  = '0;
        tol_sum_d  = '0;
        used_cnt_d = '0;
        pres_cnt_d = '0;
      end else begin
        err_sum_d  = err_next;
        tol_sum_d  = tol_next;
        used_cnt_d = used_next;
        pres_cnt_d = pres_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q  <= '0;
      tol_sum_q  <= '0;
      used_cnt_q <= '0;
      pres_cnt_q <= '0;
    end else begin
      err_sum_q  <= err_sum_d;
      tol_sum_q  <= tol_sum_d;
      used_cnt_q <= used_cnt_d;
      pres_cnt_q <= pres_cnt_d;
    end
  end

  // Hand the closed vector to the queue
  assign q_push_o              = fire & a_last_q;
  assign q_rec_o.error_sum     = err_next;
  assign q_rec_o.tolerance_sum = tol_next;
  assign q_rec_o.no_score      = (used_next == '0) || (tol_next == '0);
  assign q_rec_o.sparse        = pres_next < tshq_pkg::SparseMin;
  assign q_rec_o.new_attempt   = a_new_q;
  assign q_rec_o.time_ms       = a_time_q;

endmodule

[sv/tshq_queue.sv]
module tshq_queue #(
  parameter int unsigned DEPTH = tshq_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tshq_pkg::vec_t rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output tshq_pkg::vec_t rec_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  tshq_pkg::vec_t  entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rec_o   = entries_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed vector
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

[sv/tshq_back.sv]
module tshq_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tshq_pkg::cfg_t                cfg_i,
  input  logic                          q_empty_i,
  input  tshq_pkg::vec_t                q_rec_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tshq_pkg::ScoreW-1:0]   score_o,
  output logic                          above_threshold_o,
  output logic                          held_o,
  output logic                          timed_out_o
);

  localparam int unsigned SumW   = tshq_pkg::SumW;
  localparam int unsigned ScoreW = tshq_pkg::ScoreW;
  localparam int unsigned TimeW  = tshq_pkg::TimeW;
  localparam int unsigned StepW  = tshq_pkg::StepW;

  tshq_pkg::back_state_e state_q, state_d;

  // Control decoded from the state
  logic load, div_step, qual_fire;
  logic out_free;

  logic [SumW-1:0]   rem_q, rem_d;
  logic [SumW-1:0]   den_q;
  logic [ScoreW-1:0] quot_q, quot_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              zero_q;
  logic [TimeW-1:0]  time_q;

  logic              in_streak_q, in_streak_d;
  logic [TimeW-1:0]  streak_start_q, streak_start_d;
  logic [TimeW-1:0]  attempt_start_q, attempt_start_d;

  logic              out_valid_q, out_valid_d;
  logic [ScoreW-1:0] score_q;
  logic              above_q, held_q, tout_q;

  logic [SumW:0]     rem_shift;
  logic              rem_ge;
  logic              load_ge;
  logic [ScoreW-1:0] score;
  logic              above;
  logic [TimeW-1:0]  streak_eff;
  logic              held;
  logic              tout;

  assign out_free = ~out_valid_q | ~out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tshq_pkg::BackIdle: begin
        if (!q_empty_i && !q_rec_i.sparse) begin
          state_d = q_rec_i.no_score ? tshq_pkg::BackQual : tshq_pkg::BackDiv;
        end
      end
      tshq_pkg::BackDiv: begin
        if (step_q == StepW'(1)) begin
          state_d = tshq_pkg::BackQual;
        end
      end
      tshq_pkg::BackQual: begin
        if (out_free) begin
          state_d = tshq_pkg::BackIdle;
        end
      end
      default: state_d = tshq_pkg::BackIdle;
    endcase
  end

  // State outputs
  always_comb begin
    load      = 1'b0;
    div_step  = 1'b0;
    qual_fire = 1'b0;
    unique case (state_q)
      tshq_pkg::BackIdle: load      = ~q_empty_i;
      tshq_pkg::BackDiv:  div_step  = 1'b1;
      tshq_pkg::BackQual: qual_fire = out_free;
      default: ;
    endcase
  end

  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tshq_pkg::BackIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Divider: restoring, one quotient bit per cycle; top bit decided on load
  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = rem_shift >= (SumW+1)'(den_q);
  assign load_ge   = q_rec_i.error_sum >= q_rec_i.tolerance_sum;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    step_d = step_q;
    if (load) begin
      rem_d  = load_ge ? q_rec_i.error_sum - q_rec_i.tolerance_sum : q_rec_i.error_sum;
      quot_d = ScoreW'(load_ge);
      step_d = StepW'(tshq_pkg::DivSteps);
    end else if (div_step) begin
      rem_d  = rem_ge ? SumW'(rem_shift - (SumW+1)'(den_q)) : rem_shift[SumW-1:0];
      quot_d = {quot_q[ScoreW-2:0], rem_ge};
      step_d = step_q - StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    step_q <= step_d;
    if (load) begin
      den_q  <= q_rec_i.tolerance_sum;
      zero_q <= q_rec_i.no_score;
      time_q <= q_rec_i.time_ms;
    end
  end

  // Score, threshold compare, hold and timeout checks
  always_comb begin
    score = (zero_q || quot_q[ScoreW-1]) ? '0 : tshq_pkg::ScoreOne - quot_q;
    above = score >= cfg_i.score_threshold;
    streak_eff = in_streak_q ? streak_start_q : time_q;
    held  = above && ((time_q - streak_eff) >= TimeW'(cfg_i.hold_ms));
    tout  = ~held && ((time_q - attempt_start_q) >= TimeW'(cfg_i.time_limit_ms));
  end

  // Update attempt and streak: new attempt on load, streak on qualify
  always_comb begin
    in_streak_d     = in_streak_q;
    streak_start_d  = streak_start_q;
    attempt_start_d = attempt_start_q;
    if (load && q_rec_i.new_attempt) begin
      attempt_start_d = q_rec_i.time_ms;
      in_streak_d     = 1'b0;
    end
    if (qual_fire) begin
      in_streak_d = above;
      if (above) begin
        streak_start_d = streak_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_streak_q     <= 1'b0;
      streak_start_q  <= '0;
      attempt_start_q <= '0;
    end else begin
      in_streak_q     <= in_streak_d;
      streak_start_q  <= streak_start_d;
      attempt_start_q <= attempt_start_d;
    end
  end

  // Output register: load on qualify, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (qual_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (qual_fire) begin
      score_q <= score;
      above_q <= above;
      held_q  <= held;
      tout_q  <= tout;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign score_o           = score_q;
  assign above_threshold_o = above_q;
  assign held_o            = held_q;
  assign timed_out_o       = tout_q;

endmodule

[sv/tolerance_score_hold_qualifier_unit.sv]
// Throughput: one feature request per cycle while in_stall_o is low. A closing feature
// waits in the front register until the queue has space; the back spends a load step,
// 16 divider steps and a qualify step on a scored vector and a load and a qualify step
// on an unscored one, so short vectors can fill the queue. A result passes the front
// register, the queue and the back to the output register; a sparse vector gives no result.
// Reset: asynchronous, active low; sums, counts, hold state and registers restored.
module tolerance_score_hold_qualifier_unit #(
  parameter int unsigned QUEUE_DEPTH = tshq_pkg::QueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tshq_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [tshq_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tshq_pkg::AngleW-1:0]  measured_i,
  input  logic signed [tshq_pkg::AngleW-1:0]  template_mean_i,
  input  logic [tshq_pkg::SpreadW-1:0]        template_spread_i,
  input  logic                                measured_present_i,
  input  logic                                template_present_i,
  input  logic                                last_feature_i,
  input  logic                                new_attempt_i,
  input  logic [tshq_pkg::TimeW-1:0]          time_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tshq_pkg::ScoreW-1:0]         score_o,
  output logic                                above_threshold_o,
  output logic                                held_o,
  output logic                                timed_out_o
);

  tshq_pkg::cfg_t cfg_q, cfg_d;
  tshq_pkg::vec_t push_rec, pop_rec;
  logic           q_push, q_full, q_pop, q_empty;

  // Write configuration registers; ignore unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tshq_pkg::cfg_idx_e'(cfg_idx_i))
        tshq_pkg::CfgTolScale:  cfg_d.tol_scale       = cfg_wdata_i[tshq_pkg::ScaleW-1:0];
        tshq_pkg::CfgTolFloor:  cfg_d.tol_floor       = cfg_wdata_i[tshq_pkg::FloorW-1:0];
        tshq_pkg::CfgThreshold: cfg_d.score_threshold = cfg_wdata_i[tshq_pkg::ScoreW-1:0];
        tshq_pkg::CfgHold:      cfg_d.hold_ms         = cfg_wdata_i[tshq_pkg::HoldW-1:0];
        tshq_pkg::CfgTimeLimit: cfg_d.time_limit_ms   = cfg_wdata_i[tshq_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tol_scale       <= tshq_pkg::TolScaleRst;
      cfg_q.tol_floor       <= tshq_pkg::TolFloorRst;
      cfg_q.score_threshold <= tshq_pkg::ThresholdRst;
      cfg_q.hold_ms         <= tshq_pkg::HoldRst;
      cfg_q.time_limit_ms   <= tshq_pkg::LimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tshq_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .measured_i         (measured_i),
    .template_mean_i    (template_mean_i),
    .template_spread_i  (template_spread_i),
    .measured_present_i (measured_present_i),
    .template_present_i (template_present_i),
    .last_feature_i     (last_feature_i),
    .new_attempt_i      (new_attempt_i),
    .time_ms_i          (time_ms_i),
    .q_full_i           (q_full),
    .q_push_o           (q_push),
    .q_rec_o            (push_rec)
  );

  tshq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rec_o   (pop_rec),
    .empty_o (q_empty)
  );

  tshq_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_empty_i         (q_empty),
    .q_rec_i           (pop_rec),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .score_o           (score_o),
    .above_threshold_o (above_threshold_o),
    .held_o            (held_o),
    .timed_out_o       (timed_out_o)
  );

endmodule

[tb/sv/tolerance_score_hold_qualifier_checker.sv]
module tolerance_score_hold_qualifier_checker
  import tshq_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [AngleW-1:0]  measured_i,
  input  logic signed [AngleW-1:0]  template_mean_i,
  input  logic [SpreadW-1:0]        template_spread_i,
  input  logic                      measured_present_i,
  input  logic                      template_present_i,
  input  logic                      last_feature_i,
  input  logic                      new_attempt_i,
  input  logic [TimeW-1:0]          time_ms_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [ScoreW-1:0]         score_i,
  input  logic                      above_threshold_i,
  input  logic                      held_i,
  input  logic                      timed_out_i,
  output int unsigned               fail_cnt_o,
  output int unsigned               pending_o
);

  // 70 percent of the features, rounded down, must carry a measurement
  localparam int unsigned        MinPresent = (FeatureCount * 7) / 10;
  localparam logic [ScoreW-1:0]  FullScore  = ScoreW'(65536);
  localparam logic [SumW+FracW-1:0] FullRatio = (SumW+FracW)'(65536);

  // Settings after reset
  localparam logic [ScaleW-1:0] ScaleInit     = ScaleW'(256);
  localparam logic [FloorW-1:0] FloorInit     = FloorW'(48);
  localparam logic [ScoreW-1:0] ThresholdInit = ScoreW'(57672);
  localparam logic [HoldW-1:0]  HoldInit      = HoldW'(300);
  localparam logic [LimitW-1:0] LimitInit     = LimitW'(15000);

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              above;
    logic              held;
    logic              timed_out;
  } verdict_t;

  // Settings as last written
  logic [ScaleW-1:0] tol_scale;
  logic [FloorW-1:0] tol_floor;
  logic [ScoreW-1:0] threshold;
  logic [HoldW-1:0]  hold_ms;
  logic [LimitW-1:0] limit_ms;

  // Running sums of the open vector and the qualifier state
  logic [SumW-1:0]  err_sum;
  logic [SumW-1:0]  tol_sum;
  logic [CntW-1:0]  used_cnt;
  logic [CntW-1:0]  present_cnt;
  logic             in_streak;
  logic [TimeW-1:0] streak_start;
  logic [TimeW-1:0] attempt_start;

  verdict_t verdicts_due[$];

  function automatic logic [SumW-1:0] sat_sum(input logic [SumW-1:0] acc,
                                              input logic [TolW-1:0] term);
    logic [SumW:0] total;
    total = {1'b0, acc} + (SumW+1)'(term);
    return (total > (SumW+1)'(SumMax)) ? SumMax : total[SumW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    fail_cnt_o++;
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic clear_sums();
    err_sum     = '0;
    tol_sum     = '0;
    used_cnt    = '0;
    present_cnt = '0;
  endtask

  task automatic write_setting();
    case (cfg_idx_e'(cfg_idx_i))
      CfgTolScale:  tol_scale = cfg_wdata_i[ScaleW-1:0];
      CfgTolFloor:  tol_floor = cfg_wdata_i[FloorW-1:0];
      CfgThreshold: threshold = cfg_wdata_i[ScoreW-1:0];
      CfgHold:      hold_ms   = cfg_wdata_i[HoldW-1:0];
      CfgTimeLimit: limit_ms  = cfg_wdata_i[LimitW-1:0];
      default: ;
    endcase
  endtask

  // Fold one feature into the open vector; on the closing one, drop it if sparse, else score and qualify
  task automatic take_feature();
    logic [ProdW-1:0]       scaled;
    logic [TolW-1:0]        tol;
    logic [TolW-1:0]        err;
    logic signed [AngleW:0] diff;
    logic [AngleW:0]        gap;
    logic [SumW+FracW-1:0]  ratio;
    logic [TimeW-1:0]       elapsed;
    verdict_t               v;

    if (measured_present_i && present_cnt != CntMax) present_cnt++;
    if (measured_present_i && template_present_i) begin
      scaled = ProdW'(tol_scale) * ProdW'(template_spread_i);
      tol    = scaled[ProdW-1:8];
      if (tol < TolW'(tol_floor)) tol = TolW'(tol_floor);
      diff = $signed({measured_i[AngleW-1], measured_i})
           - $signed({template_mean_i[AngleW-1], template_mean_i});
      gap  = diff[AngleW] ? -diff : diff;
      err  = (TolW'(gap) > tol) ? tol : TolW'(gap);
      err_sum = sat_sum(err_sum, err);
      tol_sum = sat_sum(tol_sum, tol);
      if (used_cnt != CntMax) used_cnt++;
    end
    if (!last_feature_i) return;

    if (new_attempt_i) begin
      attempt_start = time_ms_i;
      in_streak     = 1'b0;
    end
    // drop a vector with too few measurements, keep the hold state
    if (present_cnt < MinPresent) begin
      clear_sums();
      return;
    end

    if (used_cnt == '0 || tol_sum == '0) begin
      v.score = '0;
    end else begin
      ratio   = {err_sum, {FracW{1'b0}}} / (SumW+FracW)'(tol_sum);
      v.score = (ratio >= FullRatio) ? '0 : FullScore - ScoreW'(ratio);
    end
    clear_sums();

    v.above = (v.score >= threshold);
    v.held  = 1'b0;
    if (v.above) begin
      if (!in_streak) begin
        in_streak    = 1'b1;
        streak_start = time_ms_i;
      end
      elapsed = time_ms_i - streak_start;
      v.held  = (elapsed >= TimeW'(hold_ms));
    end else begin
      in_streak = 1'b0;
    end
    elapsed     = time_ms_i - attempt_start;
    v.timed_out = !v.held && (elapsed >= TimeW'(limit_ms));
    verdicts_due = {verdicts_due, v};
  endtask

  task automatic check_result();
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      report_mismatch("unexpected result, score", score_i, 0);
      return;
    end
    want = verdicts_due.pop_front();
    if (score_i !== want.score) report_mismatch("score", score_i, want.score);
    if (above_threshold_i !== want.above)
      report_mismatch("above_threshold", above_threshold_i, want.above);
    if (held_i !== want.held) report_mismatch("held", held_i, want.held);
    if (timed_out_i !== want.timed_out)
      report_mismatch("timed_out", timed_out_i, want.timed_out);
  endtask

  // Sample both channels and the register port at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_scale     = ScaleInit;
      tol_floor     = FloorInit;
      threshold     = ThresholdInit;
      hold_ms       = HoldInit;
      limit_ms      = LimitInit;
      clear_sums();
      in_streak     = 1'b0;
      streak_start  = '0;
      attempt_start = '0;
      verdicts_due.delete();
      fail_cnt_o    = 0;
      pending_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (cfg_we_i) write_setting();
      if (in_valid_i && !in_stall_i) take_feature();
      pending_o = verdicts_due.size();
    end
  end

endmodule

[tb/sv/tolerance_score_hold_qualifier_unit_tb.sv]
module tolerance_score_hold_qualifier_unit_tb;
  import tshq_pkg::*;

  localparam int unsigned ItemsPerPhase = 85;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles  = 30;

  localparam logic [CfgIdxW-1:0]       CfgUnused = CfgIdxW'(7);
  localparam logic signed [AngleW-1:0] AngleMin  = {1'b1, {(AngleW-1){1'b0}}};
  localparam logic signed [AngleW-1:0] AngleMax  = ~AngleMin;
  localparam logic [SpreadW-1:0]       SpreadMax = '1;

  typedef enum int unsigned {
    VecClose,
    VecLoose,
    VecSparse,
    VecWide,
    VecNoise
  } vec_kind_e;

  typedef struct {
    logic signed [AngleW-1:0] measured;
    logic signed [AngleW-1:0] mean;
    logic [SpreadW-1:0]       spread;
    logic                     meas_present;
    logic                     tmpl_present;
    logic                     last;
    logic                     new_attempt;
    logic [TimeW-1:0]         time_ms;
  } feature_req_t;

  logic                     clk              = 1'b0;
  logic                     rst_n            = 1'b0;
  logic                     cfg_we           = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx          = '0;
  logic [CfgDataW-1:0]      cfg_wdata        = '0;
  logic                     in_valid         = 1'b0;
  logic                     in_stall;
  logic signed [AngleW-1:0] measured         = '0;
  logic signed [AngleW-1:0] template_mean    = '0;
  logic [SpreadW-1:0]       template_spread  = '0;
  logic                     measured_present = 1'b0;
  logic                     template_present = 1'b0;
  logic                     last_feature     = 1'b0;
  logic                     new_attempt      = 1'b0;
  logic [TimeW-1:0]         time_ms          = '0;
  logic                     out_valid;
  logic                     out_stall        = 1'b0;
  logic [ScoreW-1:0]        score;
  logic                     above_threshold;
  logic                     held;
  logic                     timed_out;

  int unsigned      fail_cnt;
  int unsigned      pending;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;
  int unsigned      phase_items = 0;
  logic             hold_off    = 1'b0;
  logic             hold_off_go = 1'b0;
  logic [TimeW-1:0] now_ms      = '0;

  always #5 clk = ~clk;

  tolerance_score_hold_qualifier_unit i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .measured_i         (measured),
    .template_mean_i    (template_mean),
    .template_spread_i  (template_spread),
    .measured_present_i (measured_present),
    .template_present_i (template_present),
    .last_feature_i     (last_feature),
    .new_attempt_i      (new_attempt),
    .time_ms_i          (time_ms),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .score_o            (score),
    .above_threshold_o  (above_threshold),
    .held_o             (held),
    .timed_out_o        (timed_out)
  );

  tolerance_score_hold_qualifier_checker i_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .measured_i         (measured),
    .template_mean_i    (template_mean),
    .template_spread_i  (template_spread),
    .measured_present_i (measured_present),
    .template_present_i (template_present),
    .last_feature_i     (last_feature),
    .new_attempt_i      (new_attempt),
    .time_ms_i          (time_ms),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .score_i            (score),
    .above_threshold_i  (above_threshold),
    .held_i             (held),
    .timed_out_i        (timed_out),
    .fail_cnt_o         (fail_cnt),
    .pending_o          (pending)
  );

  // Stall the result channel at random, or hold it off entirely
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < rx_idle_pct);
  end

  // Hold off the receiver for a long stretch so the block fills and stalls
  initial begin
    wait (hold_off_go);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tolerance_score_hold_qualifier_unit test failed");
    $finish;
  end

  task automatic send_request(input feature_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    measured         <= r.measured;
    template_mean    <= r.mean;
    template_spread  <= r.spread;
    measured_present <= r.meas_present;
    template_present <= r.tmpl_present;
    last_feature     <= r.last;
    new_attempt      <= r.new_attempt;
    time_ms          <= r.time_ms;
    phase_items++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Write every register, with junk above each width narrower than the data port, plus an unmapped index
  task automatic program_settings(input logic [ScaleW-1:0] scale,
                                  input logic [FloorW-1:0] floor_v,
                                  input logic [ScoreW-1:0] thr,
                                  input logic [HoldW-1:0]  hold_v,
                                  input logic [LimitW-1:0] limit_v);
    write_reg(CfgTolScale, CfgDataW'({$urandom, scale}));
    write_reg(CfgTolFloor, CfgDataW'({$urandom, floor_v}));
    write_reg(CfgThreshold, CfgDataW'({$urandom, thr}));
    write_reg(CfgHold, CfgDataW'({$urandom, hold_v}));
    write_reg(CfgTimeLimit, limit_v);
    write_reg(CfgUnused, CfgDataW'($urandom));
  endtask

  task automatic program_moderate();
    program_settings(ScaleW'($urandom_range(512, 128)), FloorW'($urandom_range(128, 16)),
                     ScoreW'($urandom_range(62000, 40000)), HoldW'($urandom_range(600)),
                     LimitW'($urandom_range(20000, 1000)));
  endtask

  // Drop valid, wait for every result, then let any sparse vector clear the block
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic send_vector(input vec_kind_e kind, input int unsigned len);
    feature_req_t r;
    int unsigned  reach;
    int unsigned  delta;
    logic         exact;

    exact = (kind == VecClose) && ($urandom_range(3) == 0);
    // advance the capture clock, now and then by a jump or to anywhere
    case ($urandom_range(49))
      0:       now_ms = $urandom;
      1, 2, 3: now_ms += $urandom_range(40000);
      default: now_ms += $urandom_range(250);
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      if (kind == VecWide) r.spread = SpreadMax - SpreadW'($urandom_range(255));
      else if ($urandom_range(3) == 0) r.spread = SpreadW'($urandom);
      else r.spread = SpreadW'($urandom_range(1500));
      r.mean = AngleW'($urandom);
      if (kind == VecNoise) begin
        r.measured     = AngleW'($urandom);
        r.meas_present = 1'($urandom_range(1));
        r.tmpl_present = 1'($urandom_range(1));
      end else begin
        reach = exact ? 0 : (kind == VecClose) ? r.spread / 8 + 2 : 4 * r.spread + 200;
        delta = $urandom_range(reach);
        if ($urandom_range(1) == 0) r.measured = r.mean + AngleW'(delta);
        else r.measured = r.mean - AngleW'(delta);
        r.meas_present = (kind == VecSparse) ? 1'($urandom_range(1))
                                             : ($urandom_range(19) != 0);
        r.tmpl_present = ($urandom_range(9) != 0);
      end
      r.last        = (i == len - 1) || (kind == VecNoise && $urandom_range(7) == 0);
      r.new_attempt = r.last ? ($urandom_range(7) == 0) : 1'($urandom_range(1));
      r.time_ms     = r.last ? now_ms : TimeW'($urandom);
      send_request(r);
    end
  endtask

  task automatic run_random(input int unsigned items);
    int unsigned pick;
    vec_kind_e   kind;
    int unsigned len;
    phase_items = 0;
    while (phase_items < items) begin
      pick = $urandom_range(99);
      if (pick < 55) kind = VecClose;
      else if (pick < 75) kind = VecLoose;
      else if (pick < 85) kind = VecSparse;
      else if (pick < 87) kind = VecWide;
      else kind = VecNoise;
      case (kind)
        VecWide:   len = $urandom_range(72, 66);
        VecSparse: len = $urandom_range(FeatureCount, 1);
        default:   len = ($urandom_range(3) == 0) ? $urandom_range(30, 14) : FeatureCount;
      endcase
      send_vector(kind, len);
    end
  endtask

  // Under the reset settings: an empty closing request that opens an attempt, a vector
  // with nothing used that runs into the timeout, one with the angle and spread
  // extremes that opens another attempt, and an exact match that starts a streak
  task automatic run_directed();
    feature_req_t r;
    r = '{default: '0};
    r.last        = 1'b1;
    r.new_attempt = 1'b1;
    r.time_ms     = 1000;
    send_request(r);
    for (int unsigned v = 0; v < 3; v++) begin
      for (int unsigned i = 0; i < 14; i++) begin
        r.spread       = SpreadW'($urandom);
        r.mean         = AngleW'($urandom);
        r.measured     = r.mean;
        r.meas_present = 1'b1;
        r.tmpl_present = (v != 0);
        if (v == 0 || (v == 1 && i < 2)) begin
          r.measured = i[0] ? AngleMax : AngleMin;
          r.mean     = i[0] ? AngleMin : AngleMax;
          r.spread   = i[0] ? '0 : SpreadMax;
        end
        r.last        = (i == 13);
        r.new_attempt = r.last ? (v == 1) : i[0];
        r.time_ms     = r.last ? TimeW'(16000 + 250 * v) : TimeW'($urandom);
        send_request(r);
      end
    end
    now_ms = 16500;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    tx_idle_pct <= 33;
    rx_idle_pct <= 63;
    run_directed();

    for (int unsigned p = 0; p < 6; p++) begin
      settle();
      case (p)
        1:       program_settings('1, '1, '1, '1, '1);
        2:       program_settings('0, '0, '0, '0, '0);
        3:       program_settings('1, '0, ScoreW'(65536), HoldW'(1), LimitW'(500));
        default: program_moderate();
      endcase
      // swap the idling sides after two phases, then run flat out for the last two
      tx_idle_pct <= (p < 2) ? 33 : (p < 4) ? 63 : 0;
      rx_idle_pct <= (p < 2) ? 63 : (p < 4) ? 33 : 0;
      if (p == 5) hold_off_go <= 1'b1;
      // push the tolerance sum into saturation while the scale is at its top
      if (p == 1 || p == 3) send_vector(VecWide, $urandom_range(72, 66));
      run_random(ItemsPerPhase);
    end
    settle();

    if (fail_cnt == 0 && pending == 0) begin
      $display("tolerance_score_hold_qualifier_unit test passed");
    end else begin
      $display("tolerance_score_hold_qualifier_unit test failed");
    end
    $finish;
  end

endmodule
